/* hdl/ipsc_pkg.sv */
`timescale 1ns / 1ps
// ipsc_pkg: shared widths, constants and types of the incremental pid speed control core
// no dependencies; imported by every module of the block

package ipsc_pkg;

  // field and datapath widths
  localparam int SPEED_BITS  = 12;
  localparam int ACC_BITS    = 48;
  localparam int TARGET_BITS = 12;
  localparam int GAIN_BITS   = 16;
  localparam int DRIVE_BITS  = 7;
  localparam int ERR_BITS    = ((SPEED_BITS > TARGET_BITS) ? SPEED_BITS : TARGET_BITS) + 1;
  localparam int COEF_BITS   = GAIN_BITS + 6;
  localparam int PROD_BITS   = COEF_BITS + ERR_BITS;
  localparam int DELTA_BITS  = PROD_BITS + 2;
  localparam int SUM_BITS    = ((ACC_BITS > DELTA_BITS) ? ACC_BITS : DELTA_BITS) + 1;
  localparam int FRAC_BITS   = 8;

  // stream word widths, whole bytes
  localparam int IN_DATA_BITS  = ((SPEED_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((DRIVE_BITS + 7) / 8) * 8;

  // configuration port
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = GAIN_BITS;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_TARGET = 2'd0,
    REG_PROP   = 2'd1,
    REG_INTEG  = 2'd2,
    REG_DERIV  = 2'd3
  } cfg_reg_t;

  localparam logic [TARGET_BITS-1:0] TARGET_RESET = TARGET_BITS'(550);

  // divide by ten through the reciprocal 52429 / 2^19, exact below 2^18
  localparam int INTEG_RND_BITS = GAIN_BITS + 1;
  localparam logic [INTEG_RND_BITS-1:0] TENTH_ROUND = INTEG_RND_BITS'(5);
  localparam logic [15:0] RECIP_TEN   = 16'd52429;
  localparam int          RECIP_SHIFT = 19;
  localparam int          RECIP_PROD_BITS = INTEG_RND_BITS + 16;

  // accumulator limits and output clamp
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0] DRIVE_LIMIT_RAW = ACC_BITS'(100 * 256);
  localparam logic [DRIVE_BITS-1:0] DRIVE_MAX = DRIVE_BITS'(100);
  localparam logic [DRIVE_BITS-1:0] DRIVE_NEG = DRIVE_BITS'(40);

  // velocity-form coefficients, all with 8 fraction bits
  typedef struct packed {
    logic signed [COEF_BITS-1:0] c0;
    logic signed [COEF_BITS-1:0] c1;
    logic signed [COEF_BITS-1:0] c2;
  } coef_t;

endpackage

/* hdl/ipsc_regs.sv */
`timescale 1ns / 1ps
// ipsc_regs: configuration registers and registered pid coefficients
// depends on ipsc_pkg

module ipsc_regs
  import ipsc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output logic [TARGET_BITS-1:0]   target_speed,
  output coef_t                    coef
);

  logic [TARGET_BITS-1:0] target_r;
  logic [GAIN_BITS-1:0]   kp_r;
  logic [GAIN_BITS-1:0]   ki_r;
  logic [GAIN_BITS-1:0]   kd_r;
  coef_t                  coef_r;
  coef_t                  coef_nxt;

  logic [GAIN_BITS+3:0]       kd10;
  logic [INTEG_RND_BITS-1:0]  ki_rnd;
  logic [RECIP_PROD_BITS-1:0] ki_recip;
  logic [GAIN_BITS-3:0]       ki_tenth;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
      kp_r     <= '0;
      ki_r     <= '0;
      kd_r     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_TARGET: target_r <= cfg_wdata[TARGET_BITS-1:0];
        REG_PROP:   kp_r     <= cfg_wdata[GAIN_BITS-1:0];
        REG_INTEG:  ki_r     <= cfg_wdata[GAIN_BITS-1:0];
        REG_DERIV:  kd_r     <= cfg_wdata[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // 10*kd as shift-add
    kd10     = ({4'b0, kd_r} << 3) + ({4'b0, kd_r} << 1);
    // ki/10 rounded half up
    ki_rnd   = {1'b0, ki_r} + TENTH_ROUND;
    ki_recip = RECIP_PROD_BITS'(ki_rnd) * RECIP_PROD_BITS'(RECIP_TEN);
    ki_tenth = ki_recip[RECIP_SHIFT +: GAIN_BITS-2];

    coef_nxt.c0 = COEF_BITS'(kp_r) + COEF_BITS'(kd10);
    coef_nxt.c1 = COEF_BITS'(ki_tenth) - COEF_BITS'(kp_r) - COEF_BITS'({kd10, 1'b0});
    coef_nxt.c2 = COEF_BITS'(kd10);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign target_speed = target_r;
  assign coef         = coef_r;

endmodule

/* hdl/incremental_pid_speed_control_core.sv */
`timescale 1ns / 1ps
// incremental_pid_speed_control_core: top level of the velocity-form pid speed controller
// depends on ipsc_pkg and ipsc_regs

// One speed sample in, one drive word out. The core is a six-register pipeline
// (input, error, products, increment, accumulator, output) that takes a new word
// every cycle unless the output stalls. The accepting edge loads the input
// register, and the word then passes the error, product, increment, accumulator
// and output registers before out_tvalid rises. The throughput of one word per
// cycle, unstalled, is set by the accumulator stage, where the saturating add into
// the prior output closes its loop through its own register; the error history
// shifts in the error stage the same way. Each stage has its own valid bit and
// moves whenever the stage after it is free, so back pressure on the output fills
// the pipeline before in_tready drops. Gains are unsigned Q8.8, the accumulator is
// signed with 8 fraction bits and saturates at its width. The drive is 100 when the
// sum is above 100.0, 40 when the sum is negative, and the integer part of the sum
// otherwise. The user must write gains and setpoint on the cfg port only while no
// word is in flight; the core does not enforce this. The derived coefficients are
// registered in the cycle after a write, before any new word needs them.

module incremental_pid_speed_control_core
  import ipsc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // [SPEED_BITS-1:0] measured_speed
  // result stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // [6:0] drive_level
  // configuration writes
  input  logic                     cfg_wr_en,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int STAGES = 6;

  logic [TARGET_BITS-1:0] target_speed;
  coef_t                  coef;

  // per-stage valid and free flags, stage 0 is the input register
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  logic [STAGES-1:0] free;

  // stage 0: input sample
  logic [SPEED_BITS-1:0] speed_r;

  // stage 1: error and history, the register shifts on every load
  logic signed [ERR_BITS-1:0] e0_r, e1_r, e2_r;
  logic signed [ERR_BITS-1:0] e0_nxt;

  // stage 2: products
  logic signed [PROD_BITS-1:0] p0_r, p1_r, p2_r;
  logic signed [PROD_BITS-1:0] p0_nxt, p1_nxt, p2_nxt;

  // stage 3: increment
  logic signed [DELTA_BITS-1:0] delta_r;
  logic signed [DELTA_BITS-1:0] delta_nxt;

  // stage 4: accumulator (prior output)
  logic signed [ACC_BITS-1:0] prior_r;
  logic signed [ACC_BITS-1:0] prior_nxt;
  logic signed [SUM_BITS-1:0] sum_wide;

  // stage 5: output drive
  logic [DRIVE_BITS-1:0] drive_r;
  logic [DRIVE_BITS-1:0] drive_nxt;

  ipsc_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .target_speed (target_speed),
    .coef         (coef)
  );

  // a stage is free when empty or when the stage after it moves
  always_comb begin
    free[STAGES-1] = !vld_r[STAGES-1] || out_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      free[i] = !vld_r[i] || free[i+1];
    end
  end

  assign in_tready = free[0];

  always_comb begin
    vld_nxt[0] = free[0] ? in_tvalid : vld_r[0];
    for (int i = 1; i < STAGES; i++) begin
      vld_nxt[i] = free[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // datapath next values
  always_comb begin
    // error against the setpoint
    e0_nxt = ERR_BITS'(target_speed) - ERR_BITS'(speed_r);

    // one multiplier per term, operands sign-extended to product width
    p0_nxt = PROD_BITS'(coef.c0) * PROD_BITS'(e0_r);
    p1_nxt = PROD_BITS'(coef.c1) * PROD_BITS'(e1_r);
    p2_nxt = PROD_BITS'(coef.c2) * PROD_BITS'(e2_r);

    delta_nxt = DELTA_BITS'(p0_r) + DELTA_BITS'(p1_r) + DELTA_BITS'(p2_r);

    // saturating add into the accumulator
    sum_wide = SUM_BITS'(prior_r) + SUM_BITS'(delta_r);
    if (sum_wide > SUM_BITS'(ACC_MAX)) begin
      prior_nxt = ACC_MAX;
    end else if (sum_wide < SUM_BITS'(ACC_MIN)) begin
      prior_nxt = ACC_MIN;
    end else begin
      prior_nxt = sum_wide[ACC_BITS-1:0];
    end

    // drive clamp on the stored sum
    if (prior_r > DRIVE_LIMIT_RAW) begin
      drive_nxt = DRIVE_MAX;
    end else if (prior_r[ACC_BITS-1]) begin
      drive_nxt = DRIVE_NEG;
    end else begin
      drive_nxt = prior_r[FRAC_BITS +: DRIVE_BITS];
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (free[0] && in_tvalid) begin
      speed_r <= in_tdata[SPEED_BITS-1:0];
    end
    if (free[2] && vld_r[1]) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
    if (free[3] && vld_r[2]) begin
      delta_r <= delta_nxt;
    end
    if (free[5] && vld_r[4]) begin
      drive_r <= drive_nxt;
    end
  end

  // controller state: error history and prior output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_r    <= '0;
      e1_r    <= '0;
      e2_r    <= '0;
      prior_r <= '0;
    end else begin
      if (free[1] && vld_r[0]) begin
        e0_r <= e0_nxt;
        e1_r <= e0_r;
        e2_r <= e1_r;
      end
      if (free[4] && vld_r[3]) begin
        prior_r <= prior_nxt;
      end
    end
  end

  assign out_tvalid = vld_r[STAGES-1];
  assign out_tdata  = OUT_DATA_BITS'(drive_r);

endmodule

/* hdl/ipsc_checker.sv */
`timescale 1ns / 1ps
// ipsc_checker: port-level assertions for the pid speed control core
// depends on ipsc_pkg; bound to incremental_pid_speed_control_core below

module ipsc_checker
  import ipsc_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tready,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  // with nothing waiting at the output every stage is free
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output is empty");

  // drive stays within its clamp range, padding bit zero
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[DRIVE_BITS-1:0] <= DRIVE_MAX) && !out_tdata[OUT_DATA_BITS-1])
    else $error("drive level out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

endmodule

bind incremental_pid_speed_control_core ipsc_checker u_ipsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
